// File: src/tcv_pkg.sv
// ----------------------------------------------------------------------------
// tcv_pkg
// Shared constants, codes and types for the two-way cache with victim buffer.
// ----------------------------------------------------------------------------
package tcv_pkg;

	// SET_COUNT and VICTIM_ENTRIES are powers of two or small counts.
	// SET_COUNT must be a power of two.
	localparam int SET_COUNT      = 32;
	localparam int VICTIM_ENTRIES = 2;
	localparam int OFFSET_BITS    = 6;

	localparam int ADDR_W    = 32;
	localparam int CNT_W     = 32;
	localparam int WAYS      = 2;
	localparam int SET_W     = $clog2(SET_COUNT);
	localparam int BLK_W     = ADDR_W - OFFSET_BITS;
	localparam int TAG_W     = BLK_W - SET_W;
	localparam int VIC_W     = (VICTIM_ENTRIES > 1) ? $clog2(VICTIM_ENTRIES) : 1;
	localparam int OUTCOME_W = 2;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_MAIN_HIT   = 2'd0,
		OUT_VICTIM_HIT = 2'd1,
		OUT_MISS       = 2'd2
	} outcome_t;

	typedef enum logic {
		ST_IDLE,
		ST_LOOKUP
	} tcv_state_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} tcv_cmd_t;

endpackage

// File: src/two_way_cache_with_victim_buffer.sv
// ----------------------------------------------------------------------------
// two_way_cache_with_victim_buffer
// Sequence: an accepted address beat starts the registered tag RAM read and moves
// the controller to ST_LOOKUP, where lookup and update commit into the result
// register; a stalled result holds the lookup, and no new address is taken meanwhile.
// Reset: valid bits, LRU bits, victim buffer state and miss counter are set at
// once by arst_n; tag RAM contents are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
module two_way_cache_with_victim_buffer import tcv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 addr_valid,
	output logic                 addr_stall,
	input  logic [ADDR_W-1:0]    address,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [OUTCOME_W-1:0] outcome,
	output logic                 way_used,
	output logic                 evicted_to_victim,
	output logic [CNT_W-1:0]     miss_total
);

	tcv_cmd_t cmd;

	tcv_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.addr_valid (addr_valid),
		.addr_stall (addr_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.cmd        (cmd)
	);

	tcv_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.address           (address),
		.outcome           (outcome),
		.way_used          (way_used),
		.evicted_to_victim (evicted_to_victim),
		.miss_total        (miss_total)
	);

endmodule

// File: src/tcv_ram.sv
// ----------------------------------------------------------------------------
// tcv_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tcv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: src/tcv_ctrl.sv
// ----------------------------------------------------------------------------
// tcv_ctrl
// Controller: accepts an address beat, sequences the lookup and holds the
// result valid until it is taken.
// ----------------------------------------------------------------------------
module tcv_ctrl import tcv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     addr_valid,
	output logic     addr_stall,
	output logic     res_valid,
	input  logic     res_stall,
	output tcv_cmd_t cmd
);

	tcv_state_t state_q, state_d;
	logic       res_valid_q, res_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		res_valid_d = res_valid_q && res_stall;
		cmd         = '0;
		addr_stall  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				addr_stall  = 1'b0;
				cmd.capture = addr_valid;
				if (addr_valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (!res_valid_q || !res_stall) begin
					cmd.commit  = 1'b1;
					res_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res_valid = res_valid_q;

	a_capture_to_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == ST_LOOKUP)
		else $error("Accepted beat did not start a lookup.");

	a_commit_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> res_valid)
		else $error("Committed lookup did not present a result.");

	a_blocked_lookup_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOKUP && res_valid && res_stall) |=> state_q == ST_LOOKUP)
		else $error("Lookup left while the previous result was still pending.");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.capture && cmd.commit))
		else $error("Capture and commit issued together.");

endmodule

// File: src/tcv_dp.sv
// ----------------------------------------------------------------------------
// tcv_dp
// Datapath: tag RAMs, valid and LRU bits, victim buffer, miss counter and
// the result register.
// ----------------------------------------------------------------------------
module tcv_dp import tcv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcv_cmd_t             cmd,
	input  logic [ADDR_W-1:0]    address,
	output logic [OUTCOME_W-1:0] outcome,
	output logic                 way_used,
	output logic                 evicted_to_victim,
	output logic [CNT_W-1:0]     miss_total
);

	logic [ADDR_W-1:0]    addr_q;
	logic [BLK_W-1:0]     blk;
	logic [SET_W-1:0]     set_a;
	logic [TAG_W-1:0]     tag_a;
	logic [TAG_W-1:0]     tag0, tag1;
	logic [SET_COUNT-1:0] valid0_q, valid1_q, lru_q;
	logic [BLK_W-1:0]     vaddr_q [VICTIM_ENTRIES];
	logic [VICTIM_ENTRIES-1:0] vvalid_q;
	logic [VIC_W-1:0]     oldest_q;
	logic [CNT_W-1:0]     miss_counter_q;
	outcome_t             outcome_q;
	logic                 way_used_q, evicted_q;

	logic                 v0, v1, h0, h1, lru;
	logic                 vhit;
	logic [VIC_W-1:0]     vslot;
	outcome_t             res_outcome;
	logic                 res_way, res_evict, wsel;
	logic                 tag_write, victim_write, victim_clear, bump_oldest;
	logic [VIC_W-1:0]     slot_sel;
	logic [BLK_W-1:0]     evict_blk;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q <= address;
		end
	end

	assign blk   = addr_q[ADDR_W-1:OFFSET_BITS];
	assign set_a = blk[SET_W-1:0];
	assign tag_a = blk[BLK_W-1:SET_W];

	tcv_ram #(.WIDTH(TAG_W), .DEPTH(SET_COUNT)) u_tags0 (
		.clk     (clk),
		.wr_en   (cmd.commit && tag_write && !wsel),
		.wr_addr (set_a),
		.wr_data (tag_a),
		.rd_en   (cmd.capture),
		.rd_addr (address[OFFSET_BITS +: SET_W]),
		.rd_data (tag0)
	);

	tcv_ram #(.WIDTH(TAG_W), .DEPTH(SET_COUNT)) u_tags1 (
		.clk     (clk),
		.wr_en   (cmd.commit && tag_write && wsel),
		.wr_addr (set_a),
		.wr_data (tag_a),
		.rd_en   (cmd.capture),
		.rd_addr (address[OFFSET_BITS +: SET_W]),
		.rd_data (tag1)
	);

	assign v0  = valid0_q[set_a];
	assign v1  = valid1_q[set_a];
	assign lru = lru_q[set_a];
	assign h0  = v0 && (tag0 == tag_a);
	assign h1  = v1 && (tag1 == tag_a);

	// The lowest matching victim slot wins.
	always_comb begin
		vhit  = 1'b0;
		vslot = '0;
		for (int i = VICTIM_ENTRIES - 1; i >= 0; i--) begin
			if (vvalid_q[i] && vaddr_q[i] == blk) begin
				vhit  = 1'b1;
				vslot = VIC_W'(i);
			end
		end
	end

	always_comb begin
		res_outcome  = OUT_MAIN_HIT;
		res_evict    = 1'b0;
		tag_write    = 1'b0;
		victim_write = 1'b0;
		victim_clear = 1'b0;
		bump_oldest  = 1'b0;
		slot_sel     = vslot;
		wsel         = lru;
		if (h0 || h1) begin
			wsel = !h0;
		end else if (vhit) begin
			res_outcome = OUT_VICTIM_HIT;
			tag_write   = 1'b1;
			if (lru ? v1 : v0) begin
				victim_write = 1'b1;
				res_evict    = 1'b1;
			end else begin
				victim_clear = 1'b1;
			end
		end else begin
			res_outcome = OUT_MISS;
			tag_write   = 1'b1;
			if (!v1) begin
				wsel = 1'b1;
			end else if (!v0) begin
				wsel = 1'b0;
			end else begin
				slot_sel     = oldest_q;
				victim_write = 1'b1;
				bump_oldest  = 1'b1;
				res_evict    = 1'b1;
			end
		end
		res_way = wsel;
	end

	assign evict_blk = {(wsel ? tag1 : tag0), set_a};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid0_q       <= '0;
			valid1_q       <= '0;
			lru_q          <= '1;
			vvalid_q       <= '0;
			oldest_q       <= '0;
			miss_counter_q <= '0;
		end else if (cmd.commit) begin
			lru_q[set_a] <= !res_way;
			if (tag_write) begin
				if (wsel) begin
					valid1_q[set_a] <= 1'b1;
				end else begin
					valid0_q[set_a] <= 1'b1;
				end
			end
			if (victim_write) begin
				vvalid_q[slot_sel] <= 1'b1;
			end else if (victim_clear) begin
				vvalid_q[slot_sel] <= 1'b0;
			end
			if (bump_oldest) begin
				oldest_q <= (oldest_q == VIC_W'(VICTIM_ENTRIES - 1)) ? '0
					: oldest_q + 1'b1;
			end
			if (res_outcome == OUT_MISS && miss_counter_q != '1) begin
				miss_counter_q <= miss_counter_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (victim_write) begin
				vaddr_q[slot_sel] <= evict_blk;
			end
			outcome_q  <= res_outcome;
			way_used_q <= res_way;
			evicted_q  <= res_evict;
		end
	end

	assign outcome           = outcome_q;
	assign way_used          = way_used_q;
	assign evicted_to_victim = evicted_q;
	assign miss_total        = miss_counter_q;

	a_count_only_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && res_outcome != OUT_MISS) |=> $stable(miss_counter_q))
		else $error("Miss counter moved on a hit.");

	a_valid_never_drops: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ($countones(valid0_q) >= $past($countones(valid0_q)))
			&& ($countones(valid1_q) >= $past($countones(valid1_q))))
		else $error("A way valid bit was cleared.");

	a_main_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && res_outcome == OUT_MAIN_HIT) |=> $stable(vvalid_q)
			&& $stable(oldest_q))
		else $error("Main hit disturbed the victim buffer.");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-way cache with victim buffer. Address beats
// are driven from a queue, each accepted beat is run through a local model of
// the tag store, LRU bits, victim FIFO and miss counter, and each result beat
// is compared field by field with the oldest predicted access.
// ----------------------------------------------------------------------------
module tb_top;
	import tcv_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_ITEMS = 950;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		outcome_t         kind;
		logic             way;
		logic             evict;
		logic [CNT_W-1:0] misses;
	} access_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              addr_valid = 1'b0;
	logic              addr_stall;
	logic [ADDR_W-1:0] address = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic [OUTCOME_W-1:0] outcome;
	logic              way_used;
	logic              evicted_to_victim;
	logic [CNT_W-1:0]  miss_total;

	logic [ADDR_W-1:0] pending_addrs[$];
	access_result_t    expected_accesses[$];
	int                total_items = 0;
	int                taken_count = 0;
	int                errors = 0;
	int                cycles = 0;
	int                addr_gap = 0;
	int                res_gap = 0;
	logic              addr_accepted = 1'b0;
	logic              long_hold = 1'b0;
	logic              calm;

	// Local copy of the cache state.
	logic [TAG_W-1:0]  way_tag[SET_COUNT][WAYS];
	logic              way_ok[SET_COUNT][WAYS];
	logic              lru_of[SET_COUNT];
	logic [BLK_W-1:0]  vic_blk[VICTIM_ENTRIES];
	logic              vic_ok[VICTIM_ENTRIES];
	int                vic_next;
	logic [CNT_W-1:0]  misses;

	two_way_cache_with_victim_buffer i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.addr_valid        (addr_valid),
		.addr_stall        (addr_stall),
		.address           (address),
		.res_valid         (res_valid),
		.res_stall         (res_stall),
		.outcome           (outcome),
		.way_used          (way_used),
		.evicted_to_victim (evicted_to_victim),
		.miss_total        (miss_total)
	);

	assign calm = (taken_count >= total_items - 120) || (((taken_count >> 7) % 3) == 2);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic access_result_t cache_access(input logic [ADDR_W-1:0] addr);
		access_result_t   r;
		logic [BLK_W-1:0] blk;
		logic [SET_W-1:0] set_i;
		logic [TAG_W-1:0] tag;
		int               hit;
		int               slot;
		logic             w;
		blk = addr[ADDR_W-1:OFFSET_BITS];
		set_i = blk[SET_W-1:0];
		tag = blk[BLK_W-1:SET_W];
		r.evict = 1'b0;
		hit = -1;
		for (int i = WAYS - 1; i >= 0; i--)
			if (way_ok[set_i][i] && way_tag[set_i][i] == tag)
				hit = i;
		if (hit >= 0) begin
			r.kind = OUT_MAIN_HIT;
			r.way = hit[0];
			lru_of[set_i] = ~hit[0];
		end else begin
			slot = -1;
			for (int i = VICTIM_ENTRIES - 1; i >= 0; i--)
				if (vic_ok[i] && vic_blk[i] == blk)
					slot = i;
			if (slot >= 0) begin
				// The victim entry keeps its slot, so the FIFO order is untouched.
				r.kind = OUT_VICTIM_HIT;
				w = lru_of[set_i];
				if (way_ok[set_i][w]) begin
					vic_blk[slot] = {way_tag[set_i][w], set_i};
					r.evict = 1'b1;
				end else begin
					vic_ok[slot] = 1'b0;
				end
			end else begin
				r.kind = OUT_MISS;
				if (misses != '1)
					misses = misses + 1'b1;
				if (!way_ok[set_i][1]) begin
					w = 1'b1;
				end else if (!way_ok[set_i][0]) begin
					w = 1'b0;
				end else begin
					w = lru_of[set_i];
					vic_blk[vic_next] = {way_tag[set_i][w], set_i};
					vic_ok[vic_next] = 1'b1;
					vic_next = (vic_next + 1) % VICTIM_ENTRIES;
					r.evict = 1'b1;
				end
			end
			way_tag[set_i][w] = tag;
			way_ok[set_i][w] = 1'b1;
			r.way = w;
			lru_of[set_i] = ~w;
		end
		r.misses = misses;
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] block_addr(input logic [TAG_W-1:0] tag,
			input logic [SET_W-1:0] set_i, input logic [OFFSET_BITS-1:0] off);
		return {tag, set_i, off};
	endfunction

	task automatic add_item(input logic [ADDR_W-1:0] a);
		pending_addrs.insert(pending_addrs.size(), a);
	endtask

	task automatic report_mismatch(input string what);
		$display("tb: mismatch at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	// Address driver: a beat stays on the bus until it is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (addr_valid && !addr_accepted) begin
				addr_valid <= 1'b1;
			end else if (addr_gap > 0) begin
				addr_valid <= 1'b0;
				addr_gap <= addr_gap - 1;
			end else if (!calm && !long_hold && $urandom_range(0, 15) == 0) begin
				addr_valid <= 1'b0;
				addr_gap <= $urandom_range(0, 16);
			end else if (pending_addrs.size() > 0) begin
				addr_valid <= 1'b1;
				address <= pending_addrs.pop_front();
			end else begin
				addr_valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure.
	always @(negedge clk) begin
		if (arst_n) begin
			if (long_hold) begin
				res_stall <= 1'b1;
			end else if (res_gap > 0) begin
				res_stall <= 1'b1;
				res_gap <= res_gap - 1;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				res_stall <= 1'b1;
				res_gap <= $urandom_range(0, 16);
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// A long hold on the result side, so that the block fills and stalls its input.
	initial begin
		while (taken_count < 300)
			@(posedge clk);
		long_hold <= 1'b1;
		repeat (250) @(posedge clk);
		long_hold <= 1'b0;
	end

	always @(posedge clk) begin : monitor
		access_result_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_accesses.size() == 0) begin
					report_mismatch("result beat with no access outstanding");
				end else begin
					want = expected_accesses.pop_front();
					if (outcome !== want.kind)
						report_mismatch($sformatf("outcome %0d, expected %0d",
							outcome, want.kind));
					if (way_used !== want.way)
						report_mismatch($sformatf("way_used %0b, expected %0b",
							way_used, want.way));
					if (evicted_to_victim !== want.evict)
						report_mismatch($sformatf("evicted_to_victim %0b, expected %0b",
							evicted_to_victim, want.evict));
					if (miss_total !== want.misses)
						report_mismatch($sformatf("miss_total %0d, expected %0d",
							miss_total, want.misses));
				end
			end
			if (addr_valid && !addr_stall) begin
				expected_accesses.insert(expected_accesses.size(), cache_access(address));
				taken_count++;
			end
			addr_accepted <= addr_valid && !addr_stall;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		logic [TAG_W-1:0] tag_pool[4];
		logic [SET_W-1:0] set_pool[3];
		for (int s = 0; s < SET_COUNT; s++) begin
			lru_of[s] = 1'b1;
			for (int w = 0; w < WAYS; w++)
				way_ok[s][w] = 1'b0;
		end
		for (int v = 0; v < VICTIM_ENTRIES; v++)
			vic_ok[v] = 1'b0;
		vic_next = 0;
		misses = '0;

		// Fill, hit, eviction into both victim slots, FIFO wrap and victim swaps.
		add_item(block_addr('0, '0, '0));
		add_item(block_addr('0, '0, '0));
		add_item(block_addr('0, '0, '1));
		add_item(block_addr(TAG_W'(1), '0, OFFSET_BITS'(5)));
		add_item(block_addr(TAG_W'(2), '0, '0));
		add_item(block_addr('0, '0, '0));
		add_item(block_addr(TAG_W'(3), '0, '0));
		add_item(block_addr(TAG_W'(4), '0, '0));
		add_item(block_addr(TAG_W'(2), '0, OFFSET_BITS'(17)));
		add_item(block_addr(TAG_W'(3), '0, '0));
		add_item(32'hFFFF_FFFF);
		add_item(32'hFFFF_FFC0);
		add_item(block_addr('1, '0, '0));
		add_item(block_addr('0, '1, '0));
		add_item(block_addr('0, SET_W'(1), '0));
		add_item(32'hAAAA_AAAA);
		add_item(32'h5555_5555);
		add_item(block_addr('1, '1, '0));
		add_item(block_addr(TAG_W'(5), '1, '0));
		add_item(32'hFFFF_FFFF);

		// Mostly a small working set of hot blocks, with fully random addresses mixed in.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 160 == 0) begin
				foreach (tag_pool[k])
					tag_pool[k] = TAG_W'($urandom);
				foreach (set_pool[k])
					set_pool[k] = SET_W'($urandom);
			end
			if ($urandom_range(0, 9) < 3)
				add_item($urandom);
			else
				add_item(block_addr(tag_pool[$urandom_range(0, 3)],
					set_pool[$urandom_range(0, 2)], OFFSET_BITS'($urandom)));
		end
		total_items = pending_addrs.size();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (taken_count < total_items)
			@(posedge clk);
		while (expected_accesses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: two_way_cache_with_victim_buffer.f
src/tcv_pkg.sv
src/tcv_ram.sv
src/tcv_ctrl.sv
src/tcv_dp.sv
src/two_way_cache_with_victim_buffer.sv
dv/tb_top.sv
